[hdl/dos_pkg.sv]
// Shared types and constants for the differential-drive odometry step unit.
package dos_pkg;

   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;
   localparam int TRIG_W = 34;
   localparam int NUM_W  = 66;
   localparam int DEN_W  = 46;
   localparam int CSR_IDX_W = 3;

   localparam logic [1:0] CMD_STEP     = 2'd0;
   localparam logic [1:0] CMD_READ     = 2'd1;
   localparam logic [1:0] CMD_SET_POSE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_SPEED_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TURN_MIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TURN_MAX  = 3'd3;

   // Radians per second times seconds to binary angle units, scaled by 2^32.
   localparam logic [MUL_W-1:0] TURN_TO_BAM = 34'd683565276;
   localparam logic [TRIG_W-1:0] CORDIC_GAIN = 34'd652032874;

   localparam logic [29:0] ATAN_BAM [32] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
      30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
      30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
   };

   typedef struct packed {
      logic [TRIG_W-1:0] sin_val;
      logic [TRIG_W-1:0] cos_val;
   } trig_type;

endpackage

[hdl/dos_mul.sv]
// Shared signed multiplier with a registered product.
module dos_mul (
   input  logic                       clock,
   input  logic [dos_pkg::MUL_W-1:0]  op_a,
   input  logic [dos_pkg::MUL_W-1:0]  op_b,
   output logic [dos_pkg::PROD_W-1:0] product
);
   import dos_pkg::*;

   logic signed [MUL_W-1:0] sa, sb;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign sa = op_a;
   assign sb = op_b;
   // Both operands are signed, so the full-width product is sign extended.
   assign prod_in = sa * sb;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;
endmodule

[hdl/dos_div.sv]
// Restoring divider, one quotient bit per cycle, signed low word result.
module dos_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [dos_pkg::NUM_W-1:0] dividend,
   input  logic [dos_pkg::DEN_W-1:0] divisor,
   input  logic                      negate,
   output logic                      busy,
   output logic [31:0]               quotient
);
   import dos_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W+1:0] trial;

   assign rem_sh = {rem_ff, quo_ff[NUM_W-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         neg_in  = negate;
      end else if (busy_ff) begin
         // The dividend shifts out at the top while quotient bits fill the bottom.
         if (!trial[DEN_W+1]) begin
            rem_in = trial[DEN_W-1:0];
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
         end
         quo_in = {quo_ff[NUM_W-2:0], ~trial[DEN_W+1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? (32'd0 - quo_ff[31:0]) : quo_ff[31:0];
endmodule

[hdl/dos_cordic.sv]
// Rotation-mode CORDIC on a binary angle, one micro-rotation per cycle.
module dos_cordic #(
   parameter int STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [31:0]         angle,
   output logic                busy,
   output dos_pkg::trig_type   trig
);
   import dos_pkg::*;

   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [1:0]        quad_ff, quad_in;
   logic [TRIG_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [32:0]       z_ff, z_in;
   logic [4:0]        idx;
   logic [TRIG_W-1:0] tx, ty;
   logic [32:0]       atan_ext;

   assign idx      = 5'(cnt_ff);
   assign tx       = TRIG_W'($signed(cy_ff) >>> idx);
   assign ty       = TRIG_W'($signed(cx_ff) >>> idx);
   assign atan_ext = {3'b000, ATAN_BAM[idx]};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quad_in = quad_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quad_in = angle[31:30];
         cx_in   = CORDIC_GAIN;
         cy_in   = '0;
         z_in    = {3'b000, angle[29:0]};
      end else if (busy_ff) begin
         if (!z_ff[32]) begin
            cx_in = cx_ff - tx;
            cy_in = cy_ff + ty;
            z_in  = z_ff - atan_ext;
         end else begin
            cx_in = cx_ff + tx;
            cy_in = cy_ff - ty;
            z_in  = z_ff + atan_ext;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quad_ff <= quad_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      z_ff    <= z_in;
   end

   // The remainder angle was below a quarter turn; the quadrant rotates the result.
   always_comb begin
      unique case (quad_ff)
         2'd0: begin
            trig.cos_val = cx_ff;
            trig.sin_val = cy_ff;
         end
         2'd1: begin
            trig.cos_val = TRIG_W'(0) - cy_ff;
            trig.sin_val = cx_ff;
         end
         2'd2: begin
            trig.cos_val = TRIG_W'(0) - cx_ff;
            trig.sin_val = TRIG_W'(0) - cy_ff;
         end
         default: begin
            trig.cos_val = cy_ff;
            trig.sin_val = TRIG_W'(0) - cx_ff;
         end
      endcase
   end

   assign busy = busy_ff;
endmodule

[hdl/diff_drive_odometry_step_unit.sv]
// Differential-drive odometry step unit: top level with the step sequencer.
//
// The req_ channel takes one command beat at a time: step (integrate speed and
// turn rate over time_step), read (report and clear the wheel counts, bump the
// frame counter) or set pose. Every request beat produces exactly one rsp_ beat
// carrying the pose after the command and, for a read, the counts.
// Read, set pose and the unused command answer one cycle after acceptance.
// A step runs through one shared multiplier, one CORDIC unit and one restoring
// divider under the sequencer: a straight step waits for one CORDIC pass, a
// turning step for two CORDIC passes and two divisions for the arc displacement.
// The next request is taken in the cycle after the response beat is accepted.
// req_ready is high only while the unit is idle; it stays low while a result
// waits for rsp_ready, so a stalled receiver holds the whole unit.
// Reset clears the pose and counts, sets the frame counter to one and loads
// the default speed and turn limits. The csr_ port writes a limit register;
// indexes above the list are ignored.
module diff_drive_odometry_step_unit #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [dos_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                     csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_command,
   input  logic signed [31:0]              req_v_des,
   input  logic signed [31:0]              req_w_des,
   input  logic [15:0]                     req_time_step,
   input  logic signed [31:0]              req_pose_x,
   input  logic signed [31:0]              req_pose_y,
   input  logic signed [31:0]              req_pose_yaw,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [31:0]              rsp_cur_x,
   output logic signed [31:0]              rsp_cur_y,
   output logic signed [31:0]              rsp_cur_heading,
   output logic [15:0]                     rsp_frame_count,
   output logic signed [15:0]              rsp_count_front_right,
   output logic signed [15:0]              rsp_count_front_left,
   output logic signed [15:0]              rsp_count_rear_right,
   output logic signed [15:0]              rsp_count_rear_left
);
   import dos_pkg::*;

   typedef enum logic [19:0] {
      ST_IDLE     = 20'h00001,
      ST_PREP     = 20'h00002,
      ST_HDG_MAG  = 20'h00004,
      ST_HDG_LO   = 20'h00008,
      ST_HDG_HI   = 20'h00010,
      ST_HDG_NEW  = 20'h00020,
      ST_COR0     = 20'h00040,
      ST_COR1     = 20'h00080,
      ST_ARC_MX   = 20'h00100,
      ST_ARC_DX   = 20'h00200,
      ST_DIV_X    = 20'h00400,
      ST_ARC_DY   = 20'h00800,
      ST_DIV_Y    = 20'h01000,
      ST_STR_VDT  = 20'h02000,
      ST_STR_VCAP = 20'h04000,
      ST_STR_MC   = 20'h08000,
      ST_STR_MS   = 20'h10000,
      ST_STR_DY   = 20'h20000,
      ST_UPD      = 20'h40000,
      ST_RESP     = 20'h80000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] speed_min_ff, speed_max_ff, turn_min_ff, turn_max_ff;
   logic [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, head_ff, head_in;
   logic [15:0] frame_ff, frame_in;
   logic [15:0] acc_fr_ff, acc_fr_in, acc_fl_ff, acc_fl_in;
   logic [15:0] acc_rr_ff, acc_rr_in, acc_rl_ff, acc_rl_in;
   logic [15:0] out_frame_ff, out_frame_in, out_fr_ff, out_fr_in, out_fl_ff, out_fl_in;
   logic [15:0] out_rr_ff, out_rr_in, out_rl_ff, out_rl_in;

   logic [31:0] v_ff, v_in, w_ff, w_in;
   logic [15:0] dt_ff, dt_in;
   logic        turn_ff, turn_in;
   logic        pneg_ff, pneg_in;
   logic [47:0] mag_ff, mag_in;
   logic [29:0] lok_ff, lok_in;
   logic [31:0] newh_ff, newh_in;
   logic [TRIG_W-1:0] s0_ff, s0_in, c0_ff, c0_in, ds_ff, ds_in, dc_ff, dc_in;
   logic [31:0] vdt_ff, vdt_in, dx_ff, dx_in, dy_ff, dy_in;

   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] mul_p;
   logic              cor_start, cor_busy;
   logic [31:0]       cor_angle;
   trig_type          cor_trig;
   logic              div_start, div_busy, div_neg;
   logic [NUM_W-1:0]  div_num;
   logic [31:0]       div_q;

   logic [42:0] vx, wx, v500, w110;
   logic [47:0] wdt;
   logic [61:0] hsum;
   logic [31:0] dlow;
   logic [31:0] wmag;
   logic [PROD_W-1:0] pabs;

   function automatic logic [31:0] clamp(input logic [31:0] x, input logic [31:0] lo,
                                         input logic [31:0] hi);
      logic [31:0] r;
      r = x;
      if ($signed(r) > $signed(hi)) r = hi;
      if ($signed(r) < $signed(lo)) r = lo;
      return r;
   endfunction

   // Divide by 2^16 rounding toward zero.
   function automatic logic [15:0] trunc16(input logic [42:0] x);
      logic [42:0] adj;
      adj = x + (x[42] ? 43'd65535 : 43'd0);
      return adj[31:16];
   endfunction

   function automatic logic [MUL_W-1:0] sext32(input logic [31:0] x);
      return {{(MUL_W-32){x[31]}}, x};
   endfunction

   dos_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   dos_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .angle (cor_angle),
      .busy  (cor_busy),
      .trig  (cor_trig)
   );

   dos_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  ({wmag, 14'd0}),
      .negate   (div_neg),
      .busy     (div_busy),
      .quotient (div_q)
   );

   assign vx   = {{11{v_ff[31]}}, v_ff};
   assign wx   = {{11{w_ff[31]}}, w_ff};
   assign v500 = (vx << 9) - (vx << 3) - (vx << 2);
   assign w110 = (wx << 7) - (wx << 4) - (wx << 1);
   assign wdt  = mul_p[47:0];
   assign hsum = mul_p[61:0] + {32'd0, lok_ff};
   assign dlow = hsum[47:16];
   assign wmag = w_ff[31] ? (32'd0 - w_ff) : w_ff;
   assign pabs = mul_p[PROD_W-1] ? (PROD_W'(0) - mul_p) : mul_p;
   assign div_num = pabs[NUM_W-1:0];
   assign div_neg = mul_p[PROD_W-1] ^ w_ff[31];

   // Shared multiplier operand selection.
   always_comb begin
      unique case (state_ff)
         ST_PREP, ST_STR_VDT: begin
            mul_a = (state_ff == ST_PREP) ? sext32(w_ff) : sext32(v_ff);
            mul_b = {{(MUL_W-16){1'b0}}, dt_ff};
         end
         ST_HDG_LO: begin
            mul_a = {{(MUL_W-16){1'b0}}, mag_ff[15:0]};
            mul_b = TURN_TO_BAM;
         end
         ST_HDG_HI: begin
            mul_a = {{(MUL_W-32){1'b0}}, mag_ff[47:16]};
            mul_b = TURN_TO_BAM;
         end
         ST_ARC_MX: begin
            mul_a = sext32(v_ff);
            mul_b = ds_ff;
         end
         ST_DIV_X: begin
            mul_a = sext32(v_ff);
            mul_b = dc_ff;
         end
         ST_STR_MC: begin
            mul_a = sext32(vdt_ff);
            mul_b = c0_ff;
         end
         ST_STR_MS: begin
            mul_a = sext32(vdt_ff);
            mul_b = s0_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      head_in      = head_ff;
      frame_in     = frame_ff;
      acc_fr_in    = acc_fr_ff;
      acc_fl_in    = acc_fl_ff;
      acc_rr_in    = acc_rr_ff;
      acc_rl_in    = acc_rl_ff;
      out_frame_in = out_frame_ff;
      out_fr_in    = out_fr_ff;
      out_fl_in    = out_fl_ff;
      out_rr_in    = out_rr_ff;
      out_rl_in    = out_rl_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      dt_in        = dt_ff;
      turn_in      = turn_ff;
      pneg_in      = pneg_ff;
      mag_in       = mag_ff;
      lok_in       = lok_ff;
      newh_in      = newh_ff;
      s0_in        = s0_ff;
      c0_in        = c0_ff;
      ds_in        = ds_ff;
      dc_in        = dc_ff;
      vdt_in       = vdt_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      cor_start    = 1'b0;
      cor_angle    = head_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               out_frame_in = '0;
               out_fr_in    = '0;
               out_fl_in    = '0;
               out_rr_in    = '0;
               out_rl_in    = '0;
               state_in     = ST_RESP;
               unique case (req_command)
                  CMD_STEP: begin
                     v_in     = clamp(req_v_des, speed_min_ff, speed_max_ff);
                     w_in     = clamp(req_w_des, turn_min_ff, turn_max_ff);
                     dt_in    = req_time_step;
                     state_in = ST_PREP;
                  end
                  CMD_READ: begin
                     out_frame_in = frame_ff;
                     out_fr_in    = acc_fr_ff;
                     out_fl_in    = acc_fl_ff;
                     out_rr_in    = acc_rr_ff;
                     out_rl_in    = acc_rl_ff;
                     acc_fr_in    = '0;
                     acc_fl_in    = '0;
                     acc_rr_in    = '0;
                     acc_rl_in    = '0;
                     frame_in     = frame_ff + 16'd1;
                  end
                  CMD_SET_POSE: begin
                     pos_x_in = req_pose_x;
                     pos_y_in = req_pose_y;
                     head_in  = req_pose_yaw;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PREP: begin
            acc_fr_in = acc_fr_ff + trunc16(v500 + w110);
            acc_rr_in = acc_rr_ff + trunc16(v500 + w110);
            acc_fl_in = acc_fl_ff + trunc16(v500 - w110);
            acc_rl_in = acc_rl_ff + trunc16(v500 - w110);
            // Turning when |w| * 1000 > 1.0 in Q16.16, i.e. |w| above 65 LSBs.
            turn_in   = (wmag > 32'd65);
            cor_start = 1'b1;
            state_in  = ST_HDG_MAG;
         end
         ST_HDG_MAG: begin
            pneg_in  = wdt[47];
            mag_in   = wdt[47] ? (48'd0 - wdt) : wdt;
            state_in = ST_HDG_LO;
         end
         ST_HDG_LO: begin
            state_in = ST_HDG_HI;
         end
         ST_HDG_HI: begin
            lok_in   = mul_p[45:16];
            state_in = ST_HDG_NEW;
         end
         ST_HDG_NEW: begin
            newh_in  = pneg_ff ? (head_ff - dlow) : (head_ff + dlow);
            state_in = ST_COR0;
         end
         ST_COR0: begin
            if (!cor_busy) begin
               s0_in = cor_trig.sin_val;
               c0_in = cor_trig.cos_val;
               if (turn_ff) begin
                  cor_start = 1'b1;
                  cor_angle = newh_ff;
                  state_in  = ST_COR1;
               end else begin
                  state_in = ST_STR_VDT;
               end
            end
         end
         ST_COR1: begin
            if (!cor_busy) begin
               ds_in    = cor_trig.sin_val - s0_ff;
               dc_in    = c0_ff - cor_trig.cos_val;
               state_in = ST_ARC_MX;
            end
         end
         ST_ARC_MX: begin
            state_in = ST_ARC_DX;
         end
         ST_ARC_DX: begin
            div_start = 1'b1;
            state_in  = ST_DIV_X;
         end
         ST_DIV_X: begin
            if (!div_busy) begin
               dx_in    = div_q;
               state_in = ST_ARC_DY;
            end
         end
         ST_ARC_DY: begin
            div_start = 1'b1;
            state_in  = ST_DIV_Y;
         end
         ST_DIV_Y: begin
            if (!div_busy) begin
               dy_in    = div_q;
               state_in = ST_UPD;
            end
         end
         ST_STR_VDT: begin
            state_in = ST_STR_VCAP;
         end
         ST_STR_VCAP: begin
            vdt_in   = 32'(PROD_W'(mul_p + (mul_p[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0)))
                           >> 16);
            state_in = ST_STR_MC;
         end
         ST_STR_MC: begin
            state_in = ST_STR_MS;
         end
         ST_STR_MS: begin
            dx_in    = 32'(PROD_W'(mul_p + (mul_p[PROD_W-1] ? PROD_W'(30'h3FFFFFFF) :
                                            PROD_W'(0))) >> 30);
            state_in = ST_STR_DY;
         end
         ST_STR_DY: begin
            dy_in    = 32'(PROD_W'(mul_p + (mul_p[PROD_W-1] ? PROD_W'(30'h3FFFFFFF) :
                                            PROD_W'(0))) >> 30);
            state_in = ST_UPD;
         end
         ST_UPD: begin
            pos_x_in = pos_x_ff + dx_ff;
            pos_y_in = pos_y_ff + dy_ff;
            head_in  = newh_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         speed_min_ff <= 32'hFFFE_0000;
         speed_max_ff <= 32'h0002_0000;
         turn_min_ff  <= 32'hFFFD_0000;
         turn_max_ff  <= 32'h0003_0000;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         head_ff      <= '0;
         frame_ff     <= 16'd1;
         acc_fr_ff    <= '0;
         acc_fl_ff    <= '0;
         acc_rr_ff    <= '0;
         acc_rl_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         head_ff   <= head_in;
         frame_ff  <= frame_in;
         acc_fr_ff <= acc_fr_in;
         acc_fl_ff <= acc_fl_in;
         acc_rr_ff <= acc_rr_in;
         acc_rl_ff <= acc_rl_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_SPEED_MIN: speed_min_ff <= csr_wdata;
               REG_SPEED_MAX: speed_max_ff <= csr_wdata;
               REG_TURN_MIN:  turn_min_ff  <= csr_wdata;
               REG_TURN_MAX:  turn_max_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      out_frame_ff <= out_frame_in;
      out_fr_ff    <= out_fr_in;
      out_fl_ff    <= out_fl_in;
      out_rr_ff    <= out_rr_in;
      out_rl_ff    <= out_rl_in;
      v_ff         <= v_in;
      w_ff         <= w_in;
      dt_ff        <= dt_in;
      turn_ff      <= turn_in;
      pneg_ff      <= pneg_in;
      mag_ff       <= mag_in;
      lok_ff       <= lok_in;
      newh_ff      <= newh_in;
      s0_ff        <= s0_in;
      c0_ff        <= c0_in;
      ds_ff        <= ds_in;
      dc_ff        <= dc_in;
      vdt_ff       <= vdt_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
   end

   assign req_ready             = (state_ff == ST_IDLE);
   assign rsp_valid             = (state_ff == ST_RESP);
   assign rsp_cur_x             = pos_x_ff;
   assign rsp_cur_y             = pos_y_ff;
   assign rsp_cur_heading       = head_ff;
   assign rsp_frame_count       = out_frame_ff;
   assign rsp_count_front_right = out_fr_ff;
   assign rsp_count_front_left  = out_fl_ff;
   assign rsp_count_rear_right  = out_rr_ff;
   assign rsp_count_rear_left   = out_rl_ff;
endmodule
